@@ src/lbr_pkg.sv @@
// Package: sizes, bracket codes, stack entry and channel payload types.
`timescale 1ns / 1ps

package lbr_pkg;

    localparam int MAX_LEN = 1024;
    localparam int POS_W   = $clog2(MAX_LEN + 1);
    localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LEN_W   = 11;
    localparam int CHAR_W  = 8;

    localparam logic [CHAR_W-1:0] CH_OPEN_ROUND   = 8'h28;
    localparam logic [CHAR_W-1:0] CH_CLOSE_ROUND  = 8'h29;
    localparam logic [CHAR_W-1:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_CLOSE_CURLY  = 8'h7D;

    typedef enum logic [1:0] {
        KIND_ROUND  = 2'd0,
        KIND_SQUARE = 2'd1,
        KIND_CURLY  = 2'd2
    } t_kind;

    typedef struct packed {
        logic  is_open;
        logic  is_close;
        t_kind kind;
    } t_class;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        t_kind            kind;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
    } t_chr;

    typedef struct packed {
        logic [LEN_W-1:0] longest_length;
        logic             too_long;
    } t_res;

    function automatic t_class classify(input logic [CHAR_W-1:0] c);
        t_class r;
        r = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
        unique case (c)
            CH_OPEN_ROUND:   r = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_ROUND};
            CH_OPEN_SQUARE:  r = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_SQUARE};
            CH_OPEN_CURLY:   r = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_CURLY};
            CH_CLOSE_ROUND:  r = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_ROUND};
            CH_CLOSE_SQUARE: r = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_SQUARE};
            CH_CLOSE_CURLY:  r = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_CURLY};
            default: ;
        endcase
        return r;
    endfunction

endpackage

@@ src/lbr_ifs.sv @@
// Interfaces: character request channel and result channel.
`timescale 1ns / 1ps

interface lbr_chr_if
    import lbr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface lbr_res_if
    import lbr_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] longest_length;
    logic             too_long;

    modport source (output valid, output longest_length, output too_long, input ready);
    modport sink   (input valid, input longest_length, input too_long, output ready);
endinterface

@@ src/lbr_stack_ram.sv @@
// Bracket stack memory: one write port, one registered read port.
`timescale 1ns / 1ps

module lbr_stack_ram
    import lbr_pkg::*;
(
    input  logic     i_clk,
    input  t_ram_req i_req,
    output t_entry   o_rd_data
);

    t_entry r_mem [MAX_LEN];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_data <= r_mem[i_req.raddr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/lbr_scan.sv @@
// Scan state: position, base, best run and the two cached top stack entries.
`timescale 1ns / 1ps

module lbr_scan
    import lbr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_go,
    input  t_chr     i_chr,
    input  t_entry   i_third,
    output t_ram_req o_ram,
    output t_res     o_res
);

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LEN);

    logic [POS_W-1:0] r_cnt, n_cnt;
    logic [POS_W-1:0] r_base, n_base;
    logic [POS_W-1:0] r_charpos, n_charpos;
    logic [POS_W-1:0] r_best, n_best;
    logic             r_ovf, n_ovf;
    t_entry           r_top, n_top;
    t_entry           r_sec, n_sec;

    t_class           cls;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] run;

    always_comb begin
        n_cnt     = r_cnt;
        n_base    = r_base;
        n_charpos = r_charpos;
        n_best    = r_best;
        n_ovf     = r_ovf;
        n_top     = r_top;
        n_sec     = r_sec;
        cls       = classify(i_chr.char_code);
        pos       = r_charpos + 1'b1;
        start     = r_base;
        run       = '0;

        o_ram.we    = 1'b0;
        o_ram.waddr = r_cnt[IDX_W-1:0];
        o_ram.wdata = '{pos: pos, kind: cls.kind};

        if (i_go) begin
            if (r_charpos >= MAX_POS) begin
                // drop characters past the length limit
                n_ovf = 1'b1;
            end else begin
                n_charpos = pos;
                if (cls.is_open) begin
                    if (r_cnt < MAX_POS) begin
                        o_ram.we = 1'b1;
                        n_top    = o_ram.wdata;
                        n_sec    = r_top;
                        n_cnt    = r_cnt + 1'b1;
                    end
                end else if (cls.is_close && r_cnt != '0 && r_top.kind == cls.kind) begin
                    n_cnt = r_cnt - 1'b1;
                    start = (r_cnt > POS_W'(1)) ? r_sec.pos : r_base;
                    run   = pos - start;
                    if (run > r_best) begin
                        n_best = run;
                    end
                    n_top = r_sec;
                    n_sec = i_third;
                end else begin
                    // break the run: empty the stack and move the base
                    n_cnt  = '0;
                    n_base = pos;
                end
            end
        end

        o_res.longest_length = LEN_W'(n_best);
        o_res.too_long       = n_ovf;

        if (i_go && i_chr.last_char) begin
            n_cnt     = '0;
            n_base    = '0;
            n_charpos = '0;
            n_best    = '0;
            n_ovf     = 1'b0;
        end

        // prefetch the entry below the new second so a pop finds it next cycle
        o_ram.raddr = IDX_W'(n_cnt - POS_W'(3));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_base    <= '0;
            r_charpos <= '0;
            r_best    <= '0;
            r_ovf     <= 1'b0;
        end else begin
            r_cnt     <= n_cnt;
            r_base    <= n_base;
            r_charpos <= n_charpos;
            r_best    <= n_best;
            r_ovf     <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        r_sec <= n_sec;
    end

endmodule

@@ src/longest_balanced_bracket_run_top.sv @@
// Longest balanced bracket run: one character request per cycle unless stalled.
// A request marked last is accepted into the input register, scanned from
// there and its result is registered. Throughput: one character per cycle,
// set by the input and result registers, while no last request is stalled.
// Stall: a last request waits in the input register while a result is held.
// Reset: synchronous, active low; clears the stack count and scan state.
`timescale 1ns / 1ps

module longest_balanced_bracket_run_top
    import lbr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    lbr_chr_if.sink          i_chr,
    lbr_res_if.source        o_res
);

    logic     r_in_valid;
    t_chr     r_in;
    logic     r_out_valid;
    t_res     r_out;

    logic     out_free;
    logic     go;
    t_ram_req ram_req;
    t_entry   third;
    t_res     scan_res;

    assign out_free    = !r_out_valid || o_res.ready;
    // hold a last character until the result register is free
    assign go          = r_in_valid && (!r_in.last_char || out_free);
    assign i_chr.ready = !r_in_valid || go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_chr.ready) begin
                r_in_valid <= i_chr.valid;
            end
            if (go && r_in.last_char) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_chr.valid && i_chr.ready) begin
            r_in <= '{char_code: i_chr.char_code, last_char: i_chr.last_char};
        end
        if (go && r_in.last_char) begin
            r_out <= scan_res;
        end
    end

    lbr_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_chr   (r_in),
        .i_third (third),
        .o_ram   (ram_req),
        .o_res   (scan_res)
    );

    lbr_stack_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (third)
    );

    assign o_res.valid          = r_out_valid;
    assign o_res.longest_length = r_out.longest_length;
    assign o_res.too_long       = r_out.too_long;

endmodule

@@ src/lbr_checker.sv @@
// Port checker for the bracket run block, bound to the top level.
`timescale 1ns / 1ps

module lbr_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_in_last,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_too_long
);

    // result stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before it was taken");

    // a fresh result comes only from an earlier accepted last request
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_last, 2))
        else $error("result without a last request");

    // requests stall only behind a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("request stalled with free result register");

    // no result right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a held result keeps its overflow flag
    a_flag_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_too_long))
        else $error("overflow flag changed while held");

endmodule

bind longest_balanced_bracket_run_top lbr_checker u_lbr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_chr.valid),
    .i_in_ready     (i_chr.ready),
    .i_in_last      (i_chr.last_char),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_out_too_long (o_res.too_long)
);

@@ tb/testbench.sv @@
// Testbench: directed and random bracket strings checked against a scoreboard of predicted runs.
`timescale 1ns / 1ps

module testbench
    import lbr_pkg::*;
;

    localparam int N_ITEMS   = 1450;
    localparam int MAX_GAP   = 12;
    localparam int HOLD_OFF  = 400;
    localparam int DRAIN_CYC = 20;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
        logic              typed;
        logic [LEN_W-1:0]  run_len;
        logic              too_long;
    } t_dir_row;

    localparam int N_DIR = 23;
    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        '{CH_OPEN_ROUND,   1'b0, 1'b0, 11'd0, 1'b0},
        '{CH_CLOSE_ROUND,  1'b1, 1'b1, 11'd2, 1'b0},
        '{8'h00,           1'b1, 1'b1, 11'd0, 1'b0},
        '{8'hFF,           1'b1, 1'b1, 11'd0, 1'b0},
        '{CH_OPEN_SQUARE,  1'b0, 1'b0, 11'd0, 1'b0},
        '{CH_CLOSE_SQUARE, 1'b0, 1'b0, 11'd0, 1'b0},
        '{CH_OPEN_CURLY,   1'b0, 1'b0, 11'd0, 1'b0},
        '{CH_CLOSE_CURLY,  1'b1, 1'b1, 11'd4, 1'b0},
        // closer of the wrong kind breaks the run
        '{CH_OPEN_ROUND,   1'b0, 1'b0, 11'd0, 1'b0},
        '{CH_CLOSE_SQUARE, 1'b1, 1'b1, 11'd0, 1'b0},
        // closer on an empty stack sets the base
        '{CH_CLOSE_ROUND,  1'b0, 1'b0, 11'd0, 1'b0},
        '{CH_OPEN_ROUND,   1'b0, 1'b0, 11'd0, 1'b0},
        '{CH_CLOSE_ROUND,  1'b1, 1'b1, 11'd2, 1'b0},
        '{CH_OPEN_CURLY,   1'b0, 1'b0, 11'd0, 1'b0},
        '{CH_OPEN_SQUARE,  1'b0, 1'b0, 11'd0, 1'b0},
        '{CH_OPEN_ROUND,   1'b0, 1'b0, 11'd0, 1'b0},
        '{CH_CLOSE_ROUND,  1'b0, 1'b0, 11'd0, 1'b0},
        '{CH_CLOSE_SQUARE, 1'b0, 1'b0, 11'd0, 1'b0},
        '{CH_CLOSE_CURLY,  1'b1, 1'b0, 11'd0, 1'b0},
        // non-bracket byte inside a pair
        '{CH_OPEN_ROUND,   1'b0, 1'b0, 11'd0, 1'b0},
        '{8'h61,           1'b0, 1'b0, 11'd0, 1'b0},
        '{CH_CLOSE_ROUND,  1'b1, 1'b1, 11'd0, 1'b0},
        '{CH_OPEN_CURLY,   1'b1, 1'b1, 11'd0, 1'b0}
    };

    logic i_clk;
    logic i_rst_n;

    lbr_chr_if chr_if ();
    lbr_res_if res_if ();

    longest_balanced_bracket_run_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_chr   (chr_if),
        .o_res   (res_if)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // scan state of the predictor
    logic [POS_W-1:0] open_pos  [MAX_LEN];
    t_kind            open_kind [MAX_LEN];
    int unsigned      depth;
    int unsigned      base_pos;
    int unsigned      n_chars;
    int unsigned      best_run;
    bit               overflow;

    t_res pending_runs [$];
    int   mismatches = 0;
    int   n_sent;
    int   n_results = 0;
    bit   steady;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    function automatic void clear_scan();
        depth    = 0;
        base_pos = 0;
        n_chars  = 0;
        best_run = 0;
        overflow = 1'b0;
    endfunction

    // advance the scan by one character; returns 1 when a run length is due
    function automatic bit scan_char(input logic [CHAR_W-1:0] c, input logic last,
                                     output t_res run);
        bit          is_open;
        bit          is_close;
        t_kind       k;
        int unsigned start;
        is_open  = 1'b0;
        is_close = 1'b0;
        k        = KIND_ROUND;
        case (c)
            CH_OPEN_ROUND:   begin is_open  = 1'b1; k = KIND_ROUND;  end
            CH_OPEN_SQUARE:  begin is_open  = 1'b1; k = KIND_SQUARE; end
            CH_OPEN_CURLY:   begin is_open  = 1'b1; k = KIND_CURLY;  end
            CH_CLOSE_ROUND:  begin is_close = 1'b1; k = KIND_ROUND;  end
            CH_CLOSE_SQUARE: begin is_close = 1'b1; k = KIND_SQUARE; end
            CH_CLOSE_CURLY:  begin is_close = 1'b1; k = KIND_CURLY;  end
            default: ;
        endcase
        if (n_chars >= MAX_LEN) begin
            overflow = 1'b1;
        end else begin
            n_chars++;
            if (is_open) begin
                if (depth < MAX_LEN) begin
                    open_pos[depth]  = POS_W'(n_chars);
                    open_kind[depth] = k;
                    depth++;
                end
            end else if (is_close && depth > 0 && open_kind[depth-1] == k) begin
                depth--;
                start = (depth > 0) ? open_pos[depth-1] : base_pos;
                if (n_chars - start > best_run) begin
                    best_run = n_chars - start;
                end
            end else begin
                depth    = 0;
                base_pos = n_chars;
            end
        end
        run.longest_length = LEN_W'(best_run);
        run.too_long       = overflow;
        if (last) begin
            clear_scan();
        end
        return last;
    endfunction

    function automatic logic [CHAR_W-1:0] opener(input t_kind k);
        case (k)
            KIND_SQUARE: return CH_OPEN_SQUARE;
            KIND_CURLY:  return CH_OPEN_CURLY;
            default:     return CH_OPEN_ROUND;
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] closer(input t_kind k);
        case (k)
            KIND_SQUARE: return CH_CLOSE_SQUARE;
            KIND_CURLY:  return CH_CLOSE_CURLY;
            default:     return CH_CLOSE_ROUND;
        endcase
    endfunction

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic last,
                             input bit typed, input t_res typed_run);
        int   gap;
        t_res run;
        gap = steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            chr_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        chr_if.valid     <= 1'b1;
        chr_if.char_code <= c;
        chr_if.last_char <= last;
        do @(posedge i_clk); while (!chr_if.ready);
        if (scan_char(c, last, run)) begin
            pending_runs.push_back(typed ? typed_run : run);
        end
        n_sent++;
        @(negedge i_clk);
    endtask

    // mostly well-formed brackets with random kinds; noise only past clean_len
    task automatic send_string(input int len, input int clean_len, input int close_pct);
        t_kind             opens [$];
        t_kind             k;
        int                horizon;
        int                r;
        logic [CHAR_W-1:0] c;
        horizon = (clean_len > 0) ? clean_len : len;
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            k = t_kind'($urandom_range(0, 2));
            if (i >= clean_len && r < 10) begin
                c = CHAR_W'($urandom_range(0, 255));
                opens.delete();
            end else if (i >= clean_len && r < 16) begin
                c = closer(k);
                if (opens.size() > 0 && opens[$] == k) begin
                    void'(opens.pop_back());
                end else begin
                    opens.delete();
                end
            end else if (opens.size() > 0 &&
                         (opens.size() >= horizon - i - 1 || r < close_pct)) begin
                c = closer(opens[$]);
                void'(opens.pop_back());
            end else begin
                c = opener(k);
                opens.push_back(k);
            end
            send_char(c, i == len - 1, 1'b0, '0);
        end
    endtask

    task automatic wait_drained();
        while (pending_runs.size() != 0) @(negedge i_clk);
    endtask

    initial begin : result_sink
        int   stall;
        int   calm;
        bit   held;
        t_res want;
        res_if.ready = 1'b0;
        held = 1'b0;
        calm = 0;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            // long hold-off so that the block backs up into its input
            if (!held && n_results >= 15) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_OFF) @(negedge i_clk);
                held = 1'b1;
            end
            if (calm > 0) begin
                calm--;
                stall = 0;
            end else begin
                stall = $urandom_range(0, MAX_GAP);
                if ($urandom_range(0, 9) == 0) begin
                    calm = $urandom_range(10, 30);
                end
            end
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
            n_results++;
            if (pending_runs.size() == 0) begin
                report_mismatch("unexpected result, longest_length", res_if.longest_length, -1);
            end else begin
                want = pending_runs.pop_front();
                if (res_if.longest_length !== want.longest_length) begin
                    report_mismatch("longest_length", res_if.longest_length,
                                    want.longest_length);
                end
                if (res_if.too_long !== want.too_long) begin
                    report_mismatch("too_long", res_if.too_long, want.too_long);
                end
            end
            @(negedge i_clk);
        end
    end

    initial begin
        t_res typed_run;
        bit   long_done;
        bit   paused;
        int   len;
        n_sent           = 0;
        steady           = 1'b0;
        long_done        = 1'b0;
        paused           = 1'b0;
        chr_if.valid     = 1'b0;
        chr_if.char_code = '0;
        chr_if.last_char = 1'b0;
        clear_scan();
        i_rst_n = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < N_DIR; i++) begin
            typed_run.longest_length = DIR_ROWS[i].run_len;
            typed_run.too_long       = DIR_ROWS[i].too_long;
            send_char(DIR_ROWS[i].code, DIR_ROWS[i].last, DIR_ROWS[i].typed, typed_run);
        end
        chr_if.valid <= 1'b0;
        wait_drained();

        while (n_sent < N_ITEMS) begin
            steady = ($urandom_range(0, 4) == 0);
            if (!long_done && n_sent > 200) begin
                // overlong string: balanced over the first MAX_LEN characters, deep stack
                send_string(MAX_LEN + 4, MAX_LEN, 30);
                long_done = 1'b1;
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60)
                                                  : $urandom_range(1, 16);
                send_string(len, 0, 50);
            end
            if (long_done && !paused) begin
                chr_if.valid <= 1'b0;
                wait_drained();
                paused = 1'b1;
            end
        end
        chr_if.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYC) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
